// ----- rtl/core/dds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants of the DDS waveform generator
// Field widths, register indexes, wave codes, FSM states, unit request
// structs and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package dds_pkg;

  localparam int PHASE_W    = 16;
  localparam int SEQ_W      = 32;
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 12;
  localparam int SHAPE_W    = 11;
  localparam int FREQ_W     = 16;
  localparam int MV_W       = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Bit-serial multiplier: A x B, one bit of B per cycle
  localparam int MUL_A_W   = 16;
  localparam int MUL_B_W   = 12;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // Restoring divider: one quotient bit per cycle
  localparam int DIV_W     = 32;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Division passes: step size, sawtooth scaling, amplitude scaling
  localparam int STEP_DIV_STEPS  = 32;
  localparam int SAW_DIV_STEPS   = 27;
  localparam int SCALE_DIV_STEPS = 22;
  localparam logic [DIV_D_W-1:0] SAW_DIVISOR   = 16'd65535;
  localparam logic [DIV_D_W-1:0] SCALE_DIVISOR = 16'd1000;

  localparam logic [MUL_B_W-1:0] GAIN_1000 = 12'd1000;
  localparam logic [MUL_B_W-1:0] GAIN_2000 = 12'd2000;
  localparam logic signed [SHAPE_W-1:0] SHAPE_FULL = 11'sd1000;

  localparam logic [PHASE_W-1:0] PHASE_QUARTER = 16'd16384;
  localparam logic [PHASE_W-1:0] PHASE_3QUARTER = 16'd49152;

  // Register reset values
  localparam logic [FREQ_W-1:0] FREQ_RESET   = 16'd1000;
  localparam logic [MV_W-1:0]   AMP_RESET    = 12'd1000;
  localparam logic [MV_W-1:0]   OFFSET_RESET = 12'd1650;
  localparam logic [FREQ_W-1:0] RATE_RESET   = 16'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_SHAPE  = 3'd0,
    REG_FREQUENCY   = 3'd1,
    REG_AMPLITUDE   = 3'd2,
    REG_OFFSET      = 3'd3,
    REG_SAMPLE_RATE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_SHAPE_GO,
    ST_SHAPE_WAIT,
    ST_SAW_GO,
    ST_SAW_WAIT,
    ST_LEVEL_GO,
    ST_LEVEL_WAIT,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_HAND
  } dds_state_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_D_W-1:0]   divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  // One point of the 64-entry sine table, built from its first quarter
  function automatic logic signed [SHAPE_W-1:0] sine_at(input logic [5:0] idx);
    logic [4:0] m;
    logic signed [SHAPE_W-1:0] q;
    m = idx[4] ? (5'd16 - {1'b0, idx[3:0]}) : {1'b0, idx[3:0]};
    case (m)
      5'd0:    q = 11'sd0;
      5'd1:    q = 11'sd98;
      5'd2:    q = 11'sd195;
      5'd3:    q = 11'sd290;
      5'd4:    q = 11'sd383;
      5'd5:    q = 11'sd471;
      5'd6:    q = 11'sd556;
      5'd7:    q = 11'sd634;
      5'd8:    q = 11'sd707;
      5'd9:    q = 11'sd773;
      5'd10:   q = 11'sd831;
      5'd11:   q = 11'sd882;
      5'd12:   q = 11'sd924;
      5'd13:   q = 11'sd957;
      5'd14:   q = 11'sd981;
      5'd15:   q = 11'sd995;
      5'd16:   q = 11'sd1000;
      default: q = 11'sd0;
    endcase
    return idx[5] ? -q : q;
  endfunction

endpackage

// ----- rtl/core/dds_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_in_if: tick channel
// Valid/ready channel carrying the timestamp of one sample tick.
// ----------------------------------------------------------------------------
interface dds_in_if;
  import dds_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] tick_time_ms;

  modport source (output valid, output tick_time_ms, input ready);
  modport sink   (input valid, input tick_time_ms, output ready);
endinterface

// ----- rtl/core/dds_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_out_if: sample channel
// Valid/ready channel carrying one generated sample.
// ----------------------------------------------------------------------------
interface dds_out_if;
  import dds_pkg::*;

  logic               valid;
  logic               ready;
  logic [SEQ_W-1:0]   sample_seq;
  logic [TIME_W-1:0]  sample_time_ms;
  logic [LEVEL_W-1:0] level_mv;

  modport source (output valid, output sample_seq, output sample_time_ms,
                  output level_mv, input ready);
  modport sink   (input valid, input sample_seq, input sample_time_ms,
                  input level_mv, output ready);
endinterface

// ----- rtl/core/dds_serial_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_serial_mul: bit-serial unsigned multiplier
// Shift-and-add over the bits of B, one bit per cycle; done pulses once.
// ----------------------------------------------------------------------------
module dds_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  dds_pkg::mul_req_t             req,
  output logic                          done,
  output logic [dds_pkg::MUL_P_W-1:0]   product
);
  import dds_pkg::*;

  logic                 busy;
  logic [MUL_CNT_W-1:0] count;
  logic [MUL_P_W-1:0]   a_sh;
  logic [MUL_B_W-1:0]   b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= MUL_CNT_W'(MUL_B_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sh    <= MUL_P_W'(req.a);
      b_sh    <= req.b;
      product <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        product <= product + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// ----- rtl/core/dds_serial_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_serial_div: restoring divider, one quotient bit per cycle
// Runs req.steps iterations; a dividend pre-shifted left by the unused
// bit count yields the quotient in the low bits of the result.
// ----------------------------------------------------------------------------
module dds_serial_div (
  input  logic                        clk,
  input  logic                        rst,
  input  dds_pkg::div_req_t           req,
  output logic                        done,
  output logic [dds_pkg::DIV_W-1:0]   quotient
);
  import dds_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     work;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvsr;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  assign trial    = {rem, work[DIV_W-1]};
  assign fits     = (trial >= {1'b0, dvsr});
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? DIV_D_W'(trial - {1'b0, dvsr}) : trial[DIV_D_W-1:0];
      work <= {work[DIV_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/dds_waveform_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_waveform_generator: direct digital synthesis sample generator
// Each tick beat advances a 16-bit phase accumulator and returns one sample
// beat: the sequence number, the tick's timestamp and the output level in
// millivolts. One tick is processed at a time. Its time is set by the shared
// bit-serial divider (phase step, sawtooth ramp, amplitude scaling) and the
// shared bit-serial multiplier (once or twice per sample). A finished sample
// sits in an output register, so the next tick is accepted while the previous
// sample waits to be taken. The user must write registers through
// cfg_we/cfg_index/cfg_wdata only while no tick is in flight; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module dds_waveform_generator #(
  parameter int MAX_MV = 3300
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  dds_in_if.sink                           tick,
  dds_out_if.source                        sample
);
  import dds_pkg::*;

  // Clamp math runs in 18-bit signed: wide enough for offset +/- scaled
  // amplitude and for any MAX_MV up to 16 bits.
  localparam int LVL_W = 18;
  localparam logic signed [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_MV);

  // Configuration registers
  wave_t              wave;
  logic [FREQ_W-1:0]  freq;
  logic [MV_W-1:0]    amp;
  logic [MV_W-1:0]    offs;
  logic [FREQ_W-1:0]  rate;

  // Generator state
  dds_state_t                state, state_next;
  logic [PHASE_W-1:0]        phase;
  logic [SEQ_W-1:0]          seq_count;
  logic [TIME_W-1:0]         tick_time;
  logic signed [SHAPE_W-1:0] shape;

  // Output register
  logic               out_valid;
  logic [SEQ_W-1:0]   out_seq;
  logic [TIME_W-1:0]  out_time;
  logic [LEVEL_W-1:0] out_level;

  // Shared arithmetic units
  mul_req_t           mul_req;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;

  logic in_ready;
  logic load;

  dds_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_prod)
  );

  dds_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Shape helpers, driven from the current phase, the multiplier product and the shape register
  // ---------------------------------------------------------------------------
  logic [5:0]                sin_idx;
  logic signed [SHAPE_W-1:0] sin_cur;
  logic signed [SHAPE_W-1:0] sin_fol;
  logic signed [SHAPE_W:0]   sin_diff;
  logic [SHAPE_W:0]          sin_mag;
  logic [SHAPE_W-1:0]        sin_q;
  logic [SHAPE_W-1:0]        shape_mag;

  assign sin_idx  = phase[PHASE_W-1 -: 6];
  assign sin_cur  = sine_at(sin_idx);
  assign sin_fol  = sine_at(sin_idx + 6'd1);
  assign sin_diff = {sin_fol[SHAPE_W-1], sin_fol} - {sin_cur[SHAPE_W-1], sin_cur};
  assign sin_mag  = sin_diff[SHAPE_W] ? -sin_diff : sin_diff;
  // (next - current) * fraction / 1024, truncated toward zero by working on
  // the magnitude and restoring the sign afterwards
  assign sin_q    = SHAPE_W'(mul_prod >> 10);
  assign shape_mag = shape[SHAPE_W-1] ? -shape : shape;

  // Shape from the multiplier product, for sine and triangle
  logic signed [SHAPE_W-1:0] shape_from_prod;
  always_comb begin
    shape_from_prod = sin_cur + (sin_diff[SHAPE_W] ? -sin_q : sin_q);
    if (wave == WAVE_TRIANGLE) begin
      case (phase[PHASE_W-1 -: 2])
        2'b00:   shape_from_prod = SHAPE_W'(mul_prod >> 14);
        2'b11:   shape_from_prod = -SHAPE_FULL + SHAPE_W'(mul_prod >> 14);
        default: shape_from_prod = SHAPE_FULL - SHAPE_W'(mul_prod >> 15);
      endcase
    end
  end

  // Level: offset +/- (amplitude * |shape|) / 1000, then clamp
  logic signed [LVL_W-1:0] scaled;
  logic signed [LVL_W-1:0] lvl;
  logic [LEVEL_W-1:0]      level_clamped;
  always_comb begin
    scaled = $signed(LVL_W'(div_quo[MV_W:0]));
    lvl    = $signed(LVL_W'(offs)) + (shape[SHAPE_W-1] ? -scaled : scaled);
    if (lvl < 0) begin
      level_clamped = '0;
    end else if (lvl > MAX_LVL) begin
      level_clamped = MAX_LVL[LEVEL_W-1:0];
    end else begin
      level_clamped = lvl[LEVEL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (tick.valid) state_next = ST_STEP_GO;
      ST_STEP_GO:    state_next = ST_STEP_WAIT;
      ST_STEP_WAIT:  if (div_done) state_next = ST_SHAPE_GO;
      ST_SHAPE_GO:   state_next = (wave == WAVE_SQUARE) ? ST_LEVEL_GO : ST_SHAPE_WAIT;
      ST_SHAPE_WAIT: begin
        if (mul_done) begin
          state_next = (wave == WAVE_SAWTOOTH) ? ST_SAW_GO : ST_LEVEL_GO;
        end
      end
      ST_SAW_GO:     state_next = ST_SAW_WAIT;
      ST_SAW_WAIT:   if (div_done) state_next = ST_LEVEL_GO;
      ST_LEVEL_GO:   state_next = ST_LEVEL_WAIT;
      ST_LEVEL_WAIT: if (mul_done) state_next = ST_SCALE_GO;
      ST_SCALE_GO:   state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT: if (div_done) state_next = ST_HAND;
      ST_HAND:       if (!out_valid || sample.ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs and unit requests
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    mul_req  = '{start: 1'b0, a: phase, b: GAIN_1000};
    div_req  = '{start: 1'b0, dividend: {freq, 16'd0}, divisor: rate,
                 steps: DIV_CNT_W'(STEP_DIV_STEPS)};
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_STEP_GO: div_req.start = 1'b1;
      ST_SHAPE_GO: begin
        mul_req.start = (wave != WAVE_SQUARE);
        case (wave)
          WAVE_SINE: begin
            mul_req.a = MUL_A_W'(sin_mag);
            mul_req.b = MUL_B_W'(phase[9:0]);
          end
          WAVE_TRIANGLE: begin
            case (phase[PHASE_W-1 -: 2])
              2'b00: begin
                mul_req.a = phase;
                mul_req.b = GAIN_1000;
              end
              2'b11: begin
                mul_req.a = phase - PHASE_3QUARTER;
                mul_req.b = GAIN_1000;
              end
              default: begin
                mul_req.a = phase - PHASE_QUARTER;
                mul_req.b = GAIN_2000;
              end
            endcase
          end
          default: begin
            mul_req.a = phase;
            mul_req.b = GAIN_2000;
          end
        endcase
      end
      ST_SAW_GO: begin
        // phase * 2000 / 65535
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(mul_prod) << (DIV_W - SAW_DIV_STEPS);
        div_req.divisor  = SAW_DIVISOR;
        div_req.steps    = DIV_CNT_W'(SAW_DIV_STEPS);
      end
      ST_LEVEL_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(amp);
        mul_req.b     = MUL_B_W'(shape_mag);
      end
      ST_SCALE_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(mul_prod) << (DIV_W - SCALE_DIV_STEPS);
        div_req.divisor  = SCALE_DIVISOR;
        div_req.steps    = DIV_CNT_W'(SCALE_DIV_STEPS);
      end
      ST_HAND: load = !out_valid || sample.ready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      seq_count <= '0;
      out_valid <= 1'b0;
      wave      <= WAVE_SINE;
      freq      <= FREQ_RESET;
      amp       <= AMP_RESET;
      offs      <= OFFSET_RESET;
      rate      <= RATE_RESET;
    end else begin
      state <= state_next;

      // Advance the phase; a zero sample rate holds it
      if (state == ST_STEP_WAIT && div_done && rate != '0) begin
        phase <= phase + div_quo[PHASE_W-1:0];
      end

      if (load) begin
        seq_count <= seq_count + 1'b1;
        out_valid <= 1'b1;
      end else if (sample.ready) begin
        out_valid <= 1'b0;
      end

      // Register writes; unknown indexes drop
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVE_SHAPE:  wave <= wave_t'(cfg_wdata[1:0]);
          REG_FREQUENCY:   freq <= cfg_wdata[FREQ_W-1:0];
          REG_AMPLITUDE:   amp  <= cfg_wdata[MV_W-1:0];
          REG_OFFSET:      offs <= cfg_wdata[MV_W-1:0];
          REG_SAMPLE_RATE: rate <= cfg_wdata[FREQ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (tick.valid && in_ready) begin
      tick_time <= tick.tick_time_ms;
    end

    case (state)
      ST_SHAPE_GO: begin
        if (wave == WAVE_SQUARE) begin
          shape <= phase[PHASE_W-1] ? -SHAPE_FULL : SHAPE_FULL;
        end
      end
      ST_SHAPE_WAIT: if (mul_done && wave != WAVE_SAWTOOTH) shape <= shape_from_prod;
      ST_SAW_WAIT:   if (div_done) shape <= SHAPE_W'(div_quo) - SHAPE_FULL;
      default: ;
    endcase

    if (load) begin
      out_seq   <= seq_count + 1'b1;
      out_time  <= tick_time;
      out_level <= level_clamped;
    end
  end

  assign tick.ready            = in_ready;
  assign sample.valid          = out_valid;
  assign sample.sample_seq     = out_seq;
  assign sample.sample_time_ms = out_time;
  assign sample.level_mv       = out_level;

endmodule
